@@ rtl/eff_pkg.sv @@
package eff_pkg;

    localparam int MW = 32;
    localparam int Q_BITS = 16;
    localparam int DIV_CELLS = Q_BITS;
    localparam int SQRT_CELLS = MW;

    localparam logic [3:0] MIN_ORDER = 4'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_ORDER   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    localparam logic [Q_BITS-1:0] Q15_MAX = 16'h7fff;
    localparam logic [Q_BITS-1:0] Q15_MIN = 16'h8000;

    // Side data that rides along with each word through the square-root cells.
    typedef struct packed {
        logic              kill;
        logic [2:0]        code;
        logic              mode;
        logic signed [MW:0] num_re;
        logic signed [MW:0] num_im;
        logic signed [MW:0] trace;
    } side_t;

    typedef struct packed {
        logic              valid;
        logic [2*MW-1:0]   rad;
        logic [MW+2:0]     rem;
        logic [MW-1:0]     root;
        side_t             side;
    } sq_t;

    typedef struct packed {
        logic              valid;
        logic              kill;
        logic [2:0]        code;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [MW+2:0]     ud;
        logic [MW+4:0]     r_re;
        logic [MW+4:0]     r_im;
        logic [Q_BITS-1:0] q_re;
        logic [Q_BITS-1:0] q_im;
    } dv_t;

    typedef struct packed {
        logic [Q_BITS-1:0] re;
        logic [Q_BITS-1:0] im;
        logic [2:0]        status;
    } res_t;

endpackage

@@ rtl/eff_if.sv @@
interface eff_in_if;
    import eff_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [3:0]           moment_order;
    logic signed [MW-1:0] second_moment_xx;
    logic signed [MW-1:0] second_moment_xy;
    logic signed [MW-1:0] second_moment_yy;
    modport source(output valid, moment_order, second_moment_xx, second_moment_xy,
                   second_moment_yy, input ready);
    modport sink(input valid, moment_order, second_moment_xx, second_moment_xy,
                 second_moment_yy, output ready);
endinterface

interface eff_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ellipticity_real;
    logic signed [15:0] ellipticity_imag;
    logic [2:0]         status;
    modport source(output valid, ellipticity_real, ellipticity_imag, status, input ready);
    modport sink(input valid, ellipticity_real, ellipticity_imag, status, output ready);
endinterface

interface eff_cfg_if;
    logic valid;
    logic ready;
    logic definition_mode;
    modport source(output valid, definition_mode, input ready);
    modport sink(input valid, definition_mode, output ready);
endinterface

@@ rtl/eff_sqrt_cell.sv @@
module eff_sqrt_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  eff_pkg::sq_t d,
    output eff_pkg::sq_t q
);
    import eff_pkg::*;

    sq_t           q_reg;
    sq_t           q_next;
    logic [MW+2:0] rem_sh;
    logic [MW+2:0] trial;

    // One root bit per cell: bring down two radicand bits and try root*4+1.
    always_comb
    begin
        rem_sh = {d.rem[MW:0], d.rad[2*MW-1 -: 2]};
        trial  = {1'b0, d.root, 2'b01};
        q_next = d;
        q_next.rad = {d.rad[2*MW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            q_next.rem  = rem_sh - trial;
            q_next.root = {d.root[MW-2:0], 1'b1};
        end
        else
        begin
            q_next.rem  = rem_sh;
            q_next.root = {d.root[MW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/eff_div_cell.sv @@
module eff_div_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  eff_pkg::dv_t d,
    output eff_pkg::dv_t q
);
    import eff_pkg::*;

    dv_t           q_reg;
    dv_t           q_next;
    logic [MW+4:0] udx;
    logic [MW+4:0] diff_re;
    logic [MW+4:0] diff_im;
    logic          ge_re;
    logic          ge_im;

    // Both components share the divisor; each lane yields one quotient bit.
    always_comb
    begin
        udx     = {2'b00, d.ud};
        ge_re   = d.r_re >= udx;
        ge_im   = d.r_im >= udx;
        diff_re = d.r_re - udx;
        diff_im = d.r_im - udx;
        q_next  = d;
        q_next.r_re = ge_re ? {diff_re[MW+3:0], 1'b0} : {d.r_re[MW+3:0], 1'b0};
        q_next.r_im = ge_im ? {diff_im[MW+3:0], 1'b0} : {d.r_im[MW+3:0], 1'b0};
        q_next.q_re = {d.q_re[Q_BITS-2:0], ge_re};
        q_next.q_im = {d.q_im[Q_BITS-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/ellipticity_from_second_moments_top.sv @@
// Pipeline: a moment word loads the input stage at the edge that accepts it; then come the
// determinant stage, 32 square-root cells, the denominator stage, the magnitude stage,
// 16 divider cells and the output queue register.
// Throughput: one word per cycle; a two-entry output queue stalls the chain when full.
// Reset: asynchronous, active low; clears the mode register, all valid bits and the queue.
module ellipticity_from_second_moments_top (
    input  logic clk,
    input  logic rst_n,
    eff_cfg_if.sink cfg,
    eff_in_if.sink  moments,
    eff_out_if.source result
);
    import eff_pkg::*;

    function automatic logic [Q_BITS:0] clamp_q15(input logic neg, input logic ovf,
                                                  input logic [Q_BITS-1:0] mag);
        logic [Q_BITS:0] r;
        if (ovf)
            r = neg ? {1'b1, Q15_MIN} : {1'b1, Q15_MAX};
        else if (neg)
            r = (mag > Q15_MIN) ? {1'b1, Q15_MIN} : {1'b0, (~mag) + 16'd1};
        else
            r = (mag > Q15_MAX) ? {1'b1, Q15_MAX} : {1'b0, mag};
        return r;
    endfunction

    logic mode_reg;
    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg.valid && cfg.ready)
            mode_reg <= cfg.definition_mode;
    end
    assign cfg.ready = 1'b1;

    // Stage A: products, sums and early status.
    logic                   a_valid_reg;
    side_t                  a_side_reg, a_side_next;
    logic signed [2*MW-1:0] pa_reg, pa_next;
    logic signed [2*MW-1:0] pb_reg, pb_next;

    always_comb
    begin
        a_side_next.mode   = mode_reg;
        a_side_next.num_re = {moments.second_moment_xx[MW-1], moments.second_moment_xx}
                           - {moments.second_moment_yy[MW-1], moments.second_moment_yy};
        a_side_next.num_im = {moments.second_moment_xy, 1'b0};
        a_side_next.trace  = {moments.second_moment_xx[MW-1], moments.second_moment_xx}
                           + {moments.second_moment_yy[MW-1], moments.second_moment_yy};
        if (moments.moment_order < MIN_ORDER)
        begin
            a_side_next.kill = 1'b1;
            a_side_next.code = ST_ORDER;
        end
        else if (moments.second_moment_xx == '0 && moments.second_moment_xy == '0
                 && moments.second_moment_yy == '0)
        begin
            a_side_next.kill = 1'b1;
            a_side_next.code = ST_ZERO;
        end
        else
        begin
            a_side_next.kill = 1'b0;
            a_side_next.code = ST_OK;
        end
        pa_next = $signed({{MW{moments.second_moment_xx[MW-1]}}, moments.second_moment_xx})
                * $signed({{MW{moments.second_moment_yy[MW-1]}}, moments.second_moment_yy});
        pb_next = $signed({{MW{moments.second_moment_xy[MW-1]}}, moments.second_moment_xy})
                * $signed({{MW{moments.second_moment_xy[MW-1]}}, moments.second_moment_xy});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
        begin
            a_valid_reg <= moments.valid;
            a_side_reg  <= a_side_next;
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
        end
    end

    assign moments.ready = en;

    // Stage B: determinant, then the square-root chain.
    logic [2*MW:0] det;
    sq_t           b_next;
    sq_t           b_reg;
    sq_t           sq_link [SQRT_CELLS+1];

    always_comb
    begin
        det = {pa_reg[2*MW-1], pa_reg} - {pb_reg[2*MW-1], pb_reg};
        b_next.valid = a_valid_reg;
        b_next.rad   = det[2*MW-1:0];
        b_next.rem   = '0;
        b_next.root  = '0;
        b_next.side  = a_side_reg;
        if (!a_side_reg.kill && a_side_reg.mode && det[2*MW])
        begin
            b_next.side.kill = 1'b1;
            b_next.side.code = ST_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_reg.valid <= 1'b0;
        else if (en)
            b_reg <= b_next;
    end

    assign sq_link[0] = b_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        eff_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (sq_link[i]),
            .q     (sq_link[i+1])
        );
    end

    // Stage C: denominator.
    sq_t                  sq_last;
    logic                 c_valid_reg;
    side_t                c_side_reg;
    logic signed [MW+2:0] c_den_reg, c_den_next;

    assign sq_last = sq_link[SQRT_CELLS];

    always_comb
    begin
        c_den_next = {{2{sq_last.side.trace[MW]}}, sq_last.side.trace};
        if (sq_last.side.mode)
            c_den_next = c_den_next + {2'b00, sq_last.root, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
        begin
            c_valid_reg <= sq_last.valid;
            c_side_reg  <= sq_last.side;
            c_den_reg   <= c_den_next;
        end
    end

    // Stage D: magnitudes, overflow test and the divider chain.
    dv_t         d_next;
    dv_t         d_reg;
    dv_t         dv_link [DIV_CELLS+1];
    logic [MW:0] un_re;
    logic [MW:0] un_im;

    always_comb
    begin
        un_re = c_side_reg.num_re[MW] ? -c_side_reg.num_re : c_side_reg.num_re;
        un_im = c_side_reg.num_im[MW] ? -c_side_reg.num_im : c_side_reg.num_im;
        d_next.valid  = c_valid_reg;
        d_next.kill   = c_side_reg.kill;
        d_next.code   = c_side_reg.code;
        if (!c_side_reg.kill && c_den_reg == '0)
        begin
            d_next.kill = 1'b1;
            d_next.code = ST_INVALID;
        end
        d_next.ud     = c_den_reg[MW+2] ? -c_den_reg : c_den_reg;
        d_next.neg_re = c_side_reg.num_re[MW] ^ c_den_reg[MW+2];
        d_next.neg_im = c_side_reg.num_im[MW] ^ c_den_reg[MW+2];
        d_next.ovf_re = {3'b000, un_re} >= {d_next.ud, 1'b0};
        d_next.ovf_im = {3'b000, un_im} >= {d_next.ud, 1'b0};
        d_next.r_re   = {4'b0000, un_re};
        d_next.r_im   = {4'b0000, un_im};
        d_next.q_re   = '0;
        d_next.q_im   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg.valid <= 1'b0;
        else if (en)
            d_reg <= d_next;
    end

    assign dv_link[0] = d_reg;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        eff_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (dv_link[i]),
            .q     (dv_link[i+1])
        );
    end

    // Final sign and clamp, then a two-entry output queue.
    dv_t             dv_last;
    logic [Q_BITS:0] cl_re;
    logic [Q_BITS:0] cl_im;
    res_t            fin;

    assign dv_last = dv_link[DIV_CELLS];

    always_comb
    begin
        cl_re = clamp_q15(dv_last.neg_re, dv_last.ovf_re, dv_last.q_re);
        cl_im = clamp_q15(dv_last.neg_im, dv_last.ovf_im, dv_last.q_im);
        if (dv_last.kill)
        begin
            fin.re     = '0;
            fin.im     = '0;
            fin.status = dv_last.code;
        end
        else
        begin
            fin.re     = cl_re[Q_BITS-1:0];
            fin.im     = cl_im[Q_BITS-1:0];
            fin.status = (cl_re[Q_BITS] || cl_im[Q_BITS]) ? ST_SAT : ST_OK;
        end
    end

    res_t       head_reg, head_next;
    res_t       skid_reg, skid_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign en   = (cnt_reg != 2'd2);
    assign push = dv_last.valid && en;
    assign pop  = result.valid && result.ready;

    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        cnt_next  = cnt_reg;
        if (push && pop)
        begin
            head_next = fin;
        end
        else if (pop)
        begin
            head_next = skid_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                head_next = fin;
            else
                skid_next = fin;
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign result.valid            = (cnt_reg != 2'd0);
    assign result.ellipticity_real = head_reg.re;
    assign result.ellipticity_imag = head_reg.im;
    assign result.status           = head_reg.status;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !moments.ready)
        else $error("input accepted while output queue full");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("output queue count did not drop on read");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == ST_ZERO || result.status == ST_ORDER
                         || result.status == ST_INVALID)
        |-> result.ellipticity_real == '0 && result.ellipticity_imag == '0)
        else $error("nonzero ellipticity with a rejecting status");

endmodule
